### hw/rtl/jnps_pkg.sv
// Shared constants and types for the nine-point Jacobi stencil block.
// Used by jacobi_nine_point_stencil; no dependencies.
`default_nettype none

package jnps_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 4096;
  localparam int FRAC_BITS   = 16;

  localparam int DATA_W      = 32;
  localparam int STORE_DEPTH = MAX_WIDTH + 2;
  localparam int COL_W       = $clog2(STORE_DEPTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT + 2);
  localparam int GW_W        = 11;
  localparam int GH_W        = 13;

  localparam int SUM_W       = DATA_W + 1;
  localparam int PROD_W      = DATA_W + SUM_W;
  localparam int ACC_W       = PROD_W + 2;
  localparam int RND_W       = ACC_W - FRAC_BITS;
  localparam int RES_W       = RND_W + 1;

  localparam int OFIFO_DEPTH = 8;
  localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);
  localparam int CNT_W       = $clog2(OFIFO_DEPTH + 1);

  localparam int PADDR_W     = 5;

  typedef enum logic [2:0] {
    REG_COEF_A      = 3'd0,
    REG_COEF_B      = 3'd1,
    REG_COEF_C      = 3'd2,
    REG_GRID_WIDTH  = 3'd3,
    REG_GRID_HEIGHT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic              last;
    logic              sat;
    logic [DATA_W-1:0] data;
  } out_item_t;

endpackage

`default_nettype wire

### hw/rtl/jacobi_nine_point_stencil.sv
// Top level of the nine-point Jacobi stencil: line stores, 3x3 window,
// multiply pipeline, output queue and APB register file. Uses jnps_pkg.
// Throughput: one item per cycle; s_tready drops only while 8 results are queued or
// in flight. m_tvalid rises once the item that completes a window has passed the
// pipeline stages and its result has been written into the output queue.
// Reset clears counters, window, queue and registers; line stores are not cleared.
`default_nettype none

module jacobi_nine_point_stencil (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // s_tdata: phi_in [31:0], source_in [63:32]
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [63:0]                 s_tdata,
  // s_tuser: frame_start [0]
  input  wire logic                        s_tuser,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  // m_tdata: phi_out [31:0]
  output logic [31:0]                      m_tdata,
  output logic                             m_tlast,
  // m_tuser: saturated [0]
  output logic                             m_tuser,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [jnps_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam int DW  = jnps_pkg::DATA_W;
  localparam int CW  = jnps_pkg::COL_W;
  localparam int RW  = jnps_pkg::ROW_W;

  // Configuration registers.
  logic signed [DW-1:0]          coef_a, coef_b, coef_c;
  logic [jnps_pkg::GW_W-1:0]     grid_width;
  logic [jnps_pkg::GH_W-1:0]     grid_height;

  // Position counters.
  logic [CW-1:0] col;
  logic [RW-1:0] row;

  // Line stores.
  logic [DW-1:0] mem_up  [jnps_pkg::STORE_DEPTH];
  logic [DW-1:0] mem_mid [jnps_pkg::STORE_DEPTH];
  logic [DW-1:0] mem_src [jnps_pkg::STORE_DEPTH];
  logic [DW-1:0] rd_up, rd_mid, rd_src;

  // Stage 1.
  logic          s1_valid, s1_produce, s1_last, s1_fwd;
  logic [CW-1:0] s1_addr;
  logic [DW-1:0] s1_phi, s1_src;
  logic [DW-1:0] f_up, f_mid, f_src;
  logic [DW-1:0] up_v, mid_v, srcp_v;

  logic signed [DW-1:0] win [6];
  logic signed [DW-1:0] src_delay;

  // Stage 2.
  logic                          s2_valid, s2_last;
  logic signed [jnps_pkg::SUM_W-1:0] d_top, d_bot, sum_a, sum_b;
  logic signed [DW-1:0]          s2_src;

  // Stage 3.
  logic                          s3_valid, s3_last;
  logic signed [jnps_pkg::PROD_W-1:0] p_top, p_bot, p_a, p_b;
  logic signed [DW-1:0]          s3_src;

  // Stage 4.
  logic                          s4_valid, s4_last;
  logic signed [jnps_pkg::RND_W-1:0] s4_rnd;
  logic signed [DW-1:0]          s4_src;
  logic signed [jnps_pkg::ACC_W-1:0] acc;
  logic signed [jnps_pkg::RES_W-1:0] res;
  logic                          res_sat;
  jnps_pkg::out_item_t           res_item;

  // Output queue.
  jnps_pkg::out_item_t           ofifo [jnps_pkg::OFIFO_DEPTH];
  logic [jnps_pkg::OFIFO_AW-1:0] wptr, rptr;
  logic [jnps_pkg::CNT_W-1:0]    fcount, used;

  // Input side.
  logic          accept, pop, produce, last_pt, cfg_wr;
  logic [CW-1:0] col0, w_eff, w_lim1, col_next;
  logic [RW-1:0] row0, h_eff, h_lim1, row_next;

  always_comb begin
    if (grid_width == '0) begin
      w_eff = CW'(1);
    end else if (int'(grid_width) > jnps_pkg::MAX_WIDTH) begin
      w_eff = CW'(jnps_pkg::MAX_WIDTH);
    end else begin
      w_eff = CW'(grid_width);
    end
    if (grid_height == '0) begin
      h_eff = RW'(1);
    end else if (int'(grid_height) > jnps_pkg::MAX_HEIGHT) begin
      h_eff = RW'(jnps_pkg::MAX_HEIGHT);
    end else begin
      h_eff = RW'(grid_height);
    end
    w_lim1 = w_eff + CW'(1);
    h_lim1 = h_eff + RW'(1);

    col0 = s_tuser ? '0 : col;
    row0 = s_tuser ? '0 : row;
    produce = (row0 >= RW'(2)) && (row0 <= h_lim1) && (col0 >= CW'(2)) && (col0 <= w_lim1);
    last_pt = (row0 == h_lim1) && (col0 == w_lim1);

    if (col0 >= w_lim1) begin
      col_next = '0;
      row_next = (row0 >= h_lim1) ? '0 : row0 + RW'(1);
    end else begin
      col_next = col0 + CW'(1);
      row_next = row0;
    end
  end

  assign s_tready = (used != jnps_pkg::CNT_W'(jnps_pkg::OFIFO_DEPTH));
  assign accept   = s_tvalid && s_tready;
  assign pop      = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // Line stores: read on accept, write back from stage 1.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_up <= mem_up[col0];
    end
    if (s1_valid) begin
      mem_up[s1_addr] <= mid_v;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_mid <= mem_mid[col0];
    end
    if (s1_valid) begin
      mem_mid[s1_addr] <= s1_phi;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_src <= mem_src[col0];
    end
    if (s1_valid) begin
      mem_src[s1_addr] <= s1_src;
    end
  end

  // A read of the entry that stage 1 writes in the same cycle takes the new data.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_produce <= produce;
      s1_last    <= last_pt;
      s1_addr    <= col0;
      s1_phi     <= s_tdata[DW-1:0];
      s1_src     <= s_tdata[2*DW-1:DW];
      s1_fwd     <= s1_valid && (s1_addr == col0);
      f_up       <= mid_v;
      f_mid      <= s1_phi;
      f_src      <= s1_src;
    end
  end

  always_comb begin
    up_v   = s1_fwd ? f_up  : rd_up;
    mid_v  = s1_fwd ? f_mid : rd_mid;
    srcp_v = s1_fwd ? f_src : rd_src;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
      src_delay <= '0;
    end else if (s1_valid) begin
      win[1]    <= win[0];
      win[0]    <= up_v;
      win[3]    <= win[2];
      win[2]    <= mid_v;
      win[5]    <= win[4];
      win[4]    <= s1_phi;
      src_delay <= srcp_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && s1_produce;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
    d_top   <= {win[1][DW-1], win[1]} + {up_v[DW-1], up_v};
    d_bot   <= {win[5][DW-1], win[5]} + {s1_phi[DW-1], s1_phi};
    sum_a   <= {win[0][DW-1], win[0]} + {win[4][DW-1], win[4]};
    sum_b   <= {win[3][DW-1], win[3]} + {mid_v[DW-1], mid_v};
    s2_src  <= src_delay;
    s2_last <= s1_last;

    p_top   <= coef_c * d_top;
    p_bot   <= coef_c * d_bot;
    p_a     <= coef_a * sum_a;
    p_b     <= coef_b * sum_b;
    s3_src  <= s2_src;
    s3_last <= s2_last;

    s4_rnd  <= acc[jnps_pkg::ACC_W-1:jnps_pkg::FRAC_BITS];
    s4_src  <= s3_src;
    s4_last <= s3_last;
  end

  always_comb begin
    acc = jnps_pkg::ACC_W'(p_top) + jnps_pkg::ACC_W'(p_bot)
        + jnps_pkg::ACC_W'(p_a) + jnps_pkg::ACC_W'(p_b)
        + (jnps_pkg::ACC_W'(1) <<< (jnps_pkg::FRAC_BITS - 1));
    res = jnps_pkg::RES_W'(s4_rnd) + jnps_pkg::RES_W'(s4_src);
    res_sat = !((&res[jnps_pkg::RES_W-1:DW-1]) || !(|res[jnps_pkg::RES_W-1:DW-1]));
    res_item.last = s4_last;
    res_item.sat  = res_sat;
    if (res_sat) begin
      res_item.data = res[jnps_pkg::RES_W-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      res_item.data = res[DW-1:0];
    end
  end

  // Output queue; used counts queued results plus those still in the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr   <= '0;
      rptr   <= '0;
      fcount <= '0;
      used   <= '0;
    end else begin
      if (s4_valid) begin
        wptr <= wptr + jnps_pkg::OFIFO_AW'(1);
      end
      if (pop) begin
        rptr <= rptr + jnps_pkg::OFIFO_AW'(1);
      end
      fcount <= fcount + jnps_pkg::CNT_W'(s4_valid) - jnps_pkg::CNT_W'(pop);
      used   <= used + jnps_pkg::CNT_W'(accept && produce) - jnps_pkg::CNT_W'(pop);
    end
    if (s4_valid) begin
      ofifo[wptr] <= res_item;
    end
  end

  assign m_tvalid = (fcount != '0);
  assign m_tdata  = ofifo[rptr].data;
  assign m_tlast  = ofifo[rptr].last;
  assign m_tuser  = ofifo[rptr].sat;

  // Register file.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a      <= '0;
      coef_b      <= '0;
      coef_c      <= '0;
      grid_width  <= jnps_pkg::GW_W'(1);
      grid_height <= jnps_pkg::GH_W'(1);
    end else if (cfg_wr) begin
      case (paddr[jnps_pkg::PADDR_W-1:2])
        jnps_pkg::REG_COEF_A:      coef_a      <= pwdata;
        jnps_pkg::REG_COEF_B:      coef_b      <= pwdata;
        jnps_pkg::REG_COEF_C:      coef_c      <= pwdata;
        jnps_pkg::REG_GRID_WIDTH:  grid_width  <= pwdata[jnps_pkg::GW_W-1:0];
        jnps_pkg::REG_GRID_HEIGHT: grid_height <= pwdata[jnps_pkg::GH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[jnps_pkg::PADDR_W-1:2])
      jnps_pkg::REG_COEF_A:      prdata = coef_a;
      jnps_pkg::REG_COEF_B:      prdata = coef_b;
      jnps_pkg::REG_COEF_C:      prdata = coef_c;
      jnps_pkg::REG_GRID_WIDTH:  prdata = 32'(grid_width);
      jnps_pkg::REG_GRID_HEIGHT: prdata = 32'(grid_height);
      default:                   prdata = '0;
    endcase
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= jnps_pkg::CNT_W'(jnps_pkg::OFIFO_DEPTH))
    else $error("outstanding result count exceeds queue depth");

  a_queue_le_used: assert property (@(posedge clk) disable iff (rst)
    fcount <= used)
    else $error("queued results exceed outstanding count");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    s4_valid |-> fcount < jnps_pkg::CNT_W'(jnps_pkg::OFIFO_DEPTH))
    else $error("result written into a full queue");

  a_fwd_same_addr: assert property (@(posedge clk) disable iff (rst)
    accept && s1_valid && (s1_addr == col0) |=> s1_fwd)
    else $error("read of an entry being written was not forwarded");

endmodule

`default_nettype wire
